@@ design/lwkd_pkg.sv @@
// Package for the longest-window unit: symbol and limit widths, reset value of the limit
// register and the default string length.
// No dependencies; the interfaces, the unit and the bench refer to it by scoped names.
package lwkd_pkg;

   localparam int unsigned SYMBOL_W        = 8;
   localparam int unsigned NUM_SYMBOLS     = 256;
   localparam int unsigned LIMIT_W         = 9;
   localparam int unsigned LIMIT_RESET     = 2;
   localparam int unsigned MAX_LEN_DEFAULT = 4096;

endpackage

@@ design/lwkd_if.sv @@
// Valid/ready channel interfaces for the longest-window unit: request words carry one
// byte of the string, response words carry the result. Depends on lwkd_pkg.
interface lwkd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lwkd_pkg::SYMBOL_W-1:0] symbol;
   logic                          last_symbol;

   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface lwkd_rsp_if #(
   parameter int unsigned START_W = 12,
   parameter int unsigned LEN_W   = 13
);
   logic               valid;
   logic               ready;
   logic [START_W-1:0] best_start;
   logic [LEN_W-1:0]   best_length;
   logic               overflow;

   modport source (output valid, output best_start, output best_length, output overflow,
                   input ready);
   modport sink   (input valid, input best_start, input best_length, input overflow,
                   output ready);
endinterface

@@ design/lwkd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the window store and the symbol counts.
module lwkd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/longest_window_k_distinct_unit.sv @@
// Longest window with at most max_distinct_ff distinct byte values, found over a string
// that arrives one byte per request word, the final byte flagged by last_symbol.
// Depends on lwkd_pkg, lwkd_if and lwkd_ram.
//
// Each byte that is stored passes through S_ADD and S_CHECK, and each byte that leaves the
// window at the left end adds a pass through S_SHR_RD and S_SHR_CNT; each removal needs
// a read of the window store followed by a read and write of the symbol count RAM, and
// increments and decrements share the one write port of that RAM. Over a string every
// byte leaves at most once. The last byte passes through S_FINISH to load the response
// word, which then waits in its own register while the next string is taken in; a
// further last byte stalls only if that response has not yet been taken. The limit
// register may be written only while the unit is idle. Bytes beyond MAX_LEN are dropped
// and flag overflow in the response. Counts are cleared at once at the end of each
// string, so no clearing pass is needed.
module longest_window_k_distinct_unit #(
   parameter int unsigned MAX_LEN = lwkd_pkg::MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   lwkd_req_if.sink                     req_port,
   lwkd_rsp_if.source                   rsp_port,
   input  logic                         csr_write_enable,
   input  logic [lwkd_pkg::LIMIT_W-1:0] csr_write_data
);

   localparam int unsigned IDX_W = $clog2(MAX_LEN);
   localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
   localparam int unsigned SYM_W = lwkd_pkg::SYMBOL_W;
   localparam int unsigned LIM_W = lwkd_pkg::LIMIT_W;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_ADD     = 6'b000010,
      S_CHECK   = 6'b000100,
      S_SHR_RD  = 6'b001000,
      S_SHR_CNT = 6'b010000,
      S_FINISH  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [LIM_W-1:0]          max_distinct_ff, max_distinct_in;
   logic [LIM_W-1:0]          distinct_ff, distinct_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic [POS_W-1:0]          begin_ff, begin_in;
   logic [IDX_W-1:0]          longest_start_ff, longest_start_in;
   logic [POS_W-1:0]          longest_length_ff, longest_length_in;
   logic                      overflowed_ff, overflowed_in;
   logic                      last_ff, last_in;
   logic [SYM_W-1:0]          cnt_addr_ff, cnt_addr_in;
   logic [lwkd_pkg::NUM_SYMBOLS-1:0] cnt_valid_ff, cnt_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_start_ff, rsp_start_in;
   logic [POS_W-1:0]          rsp_length_ff, rsp_length_in;
   logic                      rsp_overflow_ff, rsp_overflow_in;

   logic                      store_we;
   logic [SYM_W-1:0]          store_rd_data;
   logic                      cnt_we;
   logic [SYM_W-1:0]          cnt_rd_addr;
   logic [POS_W-1:0]          cnt_rd_data;
   logic [POS_W-1:0]          cnt_cur;
   logic [POS_W-1:0]          cnt_next;
   logic                      cnt_dec;
   logic                      accept;
   logic                      at_limit;
   logic                      shrink;
   logic [POS_W-1:0]          win_len;
   logic                      rsp_load;

   lwkd_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (position_ff[IDX_W-1:0]),
      .wr_data (req_port.symbol),
      .rd_addr (begin_ff[IDX_W-1:0]),
      .rd_data (store_rd_data)
   );

   lwkd_ram #(
      .WIDTH (POS_W),
      .DEPTH (lwkd_pkg::NUM_SYMBOLS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_addr_ff),
      .wr_data (cnt_next),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign req_port.ready       = (state_ff == S_IDLE);
   assign accept               = req_port.valid && req_port.ready;
   assign at_limit             = (position_ff == POS_W'(MAX_LEN));
   assign store_we             = accept && !at_limit;
   assign cnt_rd_addr          = (state_ff == S_SHR_RD) ? store_rd_data : req_port.symbol;

   // A count whose valid bit is clear has not been written during this string.
   assign cnt_cur  = cnt_valid_ff[cnt_addr_ff] ? cnt_rd_data : '0;
   assign cnt_dec  = (state_ff == S_SHR_CNT);
   assign cnt_next = cnt_dec ? (cnt_cur - POS_W'(1)) : (cnt_cur + POS_W'(1));
   assign cnt_we   = (state_ff == S_ADD) || (cnt_dec && (cnt_cur != '0));

   assign shrink   = (distinct_ff > max_distinct_ff) && (begin_ff <= position_ff);
   assign win_len  = position_ff + POS_W'(1) - begin_ff;
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_port.ready);

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.best_start  = rsp_start_ff;
   assign rsp_port.best_length = rsp_length_ff;
   assign rsp_port.overflow    = rsp_overflow_ff;

   always_comb begin
      state_in          = state_ff;
      max_distinct_in   = max_distinct_ff;
      distinct_in       = distinct_ff;
      position_in       = position_ff;
      begin_in          = begin_ff;
      longest_start_in  = longest_start_ff;
      longest_length_in = longest_length_ff;
      overflowed_in     = overflowed_ff;
      last_in           = last_ff;
      cnt_addr_in       = cnt_addr_ff;
      cnt_valid_in      = cnt_valid_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_start_in      = rsp_start_ff;
      rsp_length_in     = rsp_length_ff;
      rsp_overflow_in   = rsp_overflow_ff;

      if (csr_write_enable) begin
         max_distinct_in = csr_write_data;
      end

      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cnt_we) begin
         cnt_valid_in[cnt_addr_ff] = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in     = req_port.last_symbol;
               cnt_addr_in = req_port.symbol;
               if (at_limit) begin
                  overflowed_in = 1'b1;
                  state_in      = req_port.last_symbol ? S_FINISH : S_IDLE;
               end else begin
                  state_in = S_ADD;
               end
            end
         end
         S_ADD: begin
            if (cnt_cur == '0) begin
               distinct_in = distinct_ff + LIM_W'(1);
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (shrink) begin
               state_in = S_SHR_RD;
            end else begin
               if (win_len > longest_length_ff) begin
                  longest_length_in = win_len;
                  longest_start_in  = begin_ff[IDX_W-1:0];
               end
               position_in = position_ff + POS_W'(1);
               state_in    = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_SHR_RD: begin
            cnt_addr_in = store_rd_data;
            state_in    = S_SHR_CNT;
         end
         S_SHR_CNT: begin
            if (cnt_cur == POS_W'(1)) begin
               distinct_in = distinct_ff - LIM_W'(1);
            end
            begin_in = begin_ff + POS_W'(1);
            state_in = S_CHECK;
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in      = 1'b1;
               rsp_start_in      = longest_start_ff;
               rsp_length_in     = longest_length_ff;
               rsp_overflow_in   = overflowed_ff;
               distinct_in       = '0;
               position_in       = '0;
               begin_in          = '0;
               longest_start_in  = '0;
               longest_length_in = '0;
               overflowed_in     = 1'b0;
               cnt_valid_in      = '0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         max_distinct_ff   <= LIM_W'(lwkd_pkg::LIMIT_RESET);
         distinct_ff       <= '0;
         position_ff       <= '0;
         begin_ff          <= '0;
         longest_start_ff  <= '0;
         longest_length_ff <= '0;
         overflowed_ff     <= 1'b0;
         last_ff           <= 1'b0;
         cnt_valid_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         max_distinct_ff   <= max_distinct_in;
         distinct_ff       <= distinct_in;
         position_ff       <= position_in;
         begin_ff          <= begin_in;
         longest_start_ff  <= longest_start_in;
         longest_length_ff <= longest_length_in;
         overflowed_ff     <= overflowed_in;
         last_ff           <= last_in;
         cnt_valid_ff      <= cnt_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_addr_ff     <= cnt_addr_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

`ifndef NO_ASSERTIONS
   // The left end of the window never passes one beyond the newest byte.
   a_begin_bound: assert property (@(posedge clock) disable iff (reset)
      begin_ff <= position_ff + POS_W'(1))
      else $error("window start ran past the newest byte");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_W'(MAX_LEN))
      else $error("position exceeded the string length limit");

   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= LIM_W'(lwkd_pkg::NUM_SYMBOLS))
      else $error("distinct count exceeded the number of symbol values");

   // The longest window found can never be longer than the bytes taken so far.
   a_longest_bound: assert property (@(posedge clock) disable iff (reset)
      longest_length_ff <= position_ff)
      else $error("longest window longer than the string");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for longest_window_k_distinct_unit: strings go in as request words,
// and each result word is checked against a local window predictor.
// Depends on lwkd_pkg, lwkd_if and the unit itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STRING_CAP    = lwkd_pkg::MAX_LEN_DEFAULT;
   localparam int          RANDOM_ITEMS  = 1050;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          QUIET_LIMIT   = 50000;

   typedef logic [lwkd_pkg::SYMBOL_W-1:0] sym_t;
   typedef logic [lwkd_pkg::LIMIT_W-1:0]  limit_t;
   typedef sym_t                          sym_q_t[$];

   typedef struct packed {
      logic [11:0] best_start;
      logic [12:0] best_length;
      logic        overflow;
   } window_result_t;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   csr_write_enable;
   limit_t csr_write_data;

   lwkd_req_if req_ch ();
   lwkd_rsp_if rsp_ch ();

   longest_window_k_distinct_unit #(.MAX_LEN(STRING_CAP)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_ch.sink),
      .rsp_port         (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, kept at the widths of the unit's own registers.
   limit_t         distinct_limit;
   logic [12:0]    sym_count [lwkd_pkg::NUM_SYMBOLS];
   logic [8:0]     distinct_syms;
   sym_t           byte_store [STRING_CAP];
   logic [12:0]    win_lo;
   logic [12:0]    string_pos;
   logic [11:0]    longest_lo;
   logic [12:0]    longest_len;
   logic           dropped_bytes;

   window_result_t pending_windows[$];
   int             fault_count;
   int             bytes_sent;
   bit             steady_run;

   function automatic void clear_window();
      foreach (sym_count[i]) sym_count[i] = '0;
      distinct_syms = '0;
      win_lo        = '0;
      string_pos    = '0;
      longest_lo    = '0;
      longest_len   = '0;
      dropped_bytes = 1'b0;
   endfunction

   // Adds one byte to the window and, on the last byte, queues the result word.
   function automatic void predict_window(sym_t sym, logic last);
      sym_t        oldest;
      logic [12:0] span;
      window_result_t res;
      if (string_pos < 13'(STRING_CAP)) begin
         byte_store[string_pos[11:0]] = sym;
         sym_count[sym] = sym_count[sym] + 13'd1;
         if (sym_count[sym] == 13'd1) distinct_syms = distinct_syms + 9'd1;
         while (distinct_syms > distinct_limit && win_lo <= string_pos) begin
            oldest = byte_store[win_lo[11:0]];
            if (sym_count[oldest] != '0) begin
               sym_count[oldest] = sym_count[oldest] - 13'd1;
               if (sym_count[oldest] == '0) distinct_syms = distinct_syms - 9'd1;
            end
            win_lo = win_lo + 13'd1;
         end
         span = string_pos + 13'd1 - win_lo;
         if (span > longest_len) begin
            longest_len = span;
            longest_lo  = win_lo[11:0];
         end
         string_pos = string_pos + 13'd1;
      end else begin
         dropped_bytes = 1'b1;
      end
      if (last) begin
         res.best_start  = longest_lo;
         res.best_length = longest_len;
         res.overflow    = dropped_bytes;
         pending_windows.push_back(res);
         clear_window();
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_fault(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fault_count++;
   endtask

   // Sends one byte; the valid stays high straight into the next word when no gap is drawn.
   task automatic push_byte(input sym_t sym, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.symbol      <= sym;
      req_ch.last_symbol <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_window(sym, last);
      bytes_sent++;
   endtask

   task automatic send_string(input sym_q_t syms);
      foreach (syms[i]) push_byte(syms[i], i == syms.size() - 1);
   endtask

   // Symbols are drawn from alpha values above a random base (any byte when alpha is 256), with runs of repeats.
   task automatic send_random_string(input int len, input int alpha);
      sym_t base;
      sym_t sym;
      base = sym_t'($urandom_range(0, 255));
      sym  = base;
      for (int i = 0; i < len; i++) begin
         if (i == 0 || $urandom_range(0, 9) < 6) begin
            if (alpha >= 256) sym = sym_t'($urandom_range(0, 255));
            else sym = base + sym_t'($urandom_range(0, alpha - 1));
         end
         push_byte(sym, i == len - 1);
      end
   endtask

   // Lets every outstanding result drain and the unit fall idle.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input limit_t value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      distinct_limit = value;
   endtask

   function automatic limit_t pick_limit();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0: return limit_t'(0);
         1: return limit_t'(256);
         2: return limit_t'(511);
         3: return limit_t'($urandom_range(257, 510));
         4: return limit_t'(255);
         default: begin
            if (r < 15) return limit_t'($urandom_range(1, 6));
            return limit_t'($urandom_range(7, 64));
         end
      endcase
   endfunction

   // The reset value of the limit is used here, so no register write comes first.
   task automatic test_reset_limit();
      send_string('{8'h00});
      send_string('{8'hFF, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h01});
      // Two windows of equal length: the earlier one must be kept.
      send_string('{8'h41, 8'h41, 8'h42, 8'h42, 8'h43, 8'h43});
   endtask

   task automatic test_limit_extremes();
      set_limit(limit_t'(0));
      send_string('{8'h05, 8'h05, 8'h07});
      set_limit(limit_t'(511));
      send_string('{8'h01, 8'h02, 8'h03, 8'h04});
      set_limit(limit_t'(1));
      send_string('{8'h09, 8'h09, 8'h08, 8'h08, 8'h08});
   endtask

   task automatic test_random_strings();
      int start_count;
      int len;
      int alpha;
      int r;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_ITEMS) begin
         set_limit(pick_limit());
         repeat ($urandom_range(2, 6)) begin
            steady_run = ($urandom_range(0, 7) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            if (r < 4) alpha = $urandom_range(1, 3);
            else if (r < 7) alpha = $urandom_range(4, 8);
            else if (r < 9) alpha = $urandom_range(9, 40);
            else alpha = 256;
            send_random_string(len, alpha);
         end
      end
      steady_run = 1'b0;
   endtask

   always @(posedge clock) begin
      window_result_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_windows.size() == 0) begin
            report_fault("result word with no string outstanding");
         end else begin
            want = pending_windows.pop_front();
            if (rsp_ch.best_start !== want.best_start)
               report_fault($sformatf("best_start expected %0d, got %0d",
                                      want.best_start, rsp_ch.best_start));
            if (rsp_ch.best_length !== want.best_length)
               report_fault($sformatf("best_length expected %0d, got %0d",
                                      want.best_length, rsp_ch.best_length));
            if (rsp_ch.overflow !== want.overflow)
               report_fault($sformatf("overflow expected %0b, got %0b",
                                      want.overflow, rsp_ch.overflow));
         end
      end
   end

   // Response back-pressure: after each time ready is high, it drops for a gap drawn by pick_gap, which may be empty.
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || csr_write_enable)
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.symbol      = '0;
      req_ch.last_symbol = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = limit_t'(lwkd_pkg::LIMIT_RESET);
      distinct_limit     = limit_t'(lwkd_pkg::LIMIT_RESET);
      fault_count        = 0;
      bytes_sent         = 0;
      steady_run         = 1'b0;
      clear_window();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_limit();
      test_limit_extremes();
      test_random_strings();

      settle();
      if (pending_windows.size() != 0)
         report_fault($sformatf("%0d results never arrived", pending_windows.size()));
      if (fault_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

@@ filelist.f @@
design/lwkd_pkg.sv
design/lwkd_if.sv
design/lwkd_ram.sv
design/longest_window_k_distinct_unit.sv
tb/sv/tb_top.sv
